FILE: hdl/dpb_pkg.sv
// ----------------------------------------------------------------------------
// dpb_pkg
// Types, register codes and divide-by-constant helpers for the decal pixel
// blend unit.
// ----------------------------------------------------------------------------
package dpb_pkg;

    localparam int NUM_STAGES = 5;

    typedef struct packed {
        logic [7:0] decal_red;
        logic [7:0] decal_green;
        logic [7:0] decal_blue;
        logic [7:0] decal_index;
        logic       background_present;
        logic [7:0] back_red;
        logic [7:0] back_green;
        logic [7:0] back_blue;
    } in_t;

    typedef struct packed {
        logic       write_pixel;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } out_t;

    typedef enum logic [2:0] {
        REG_BLEND_PERCENT      = 3'd0,
        REG_USE_DRAWING_COLORS = 3'd1,
        REG_CLEAR_BACKGROUND   = 3'd2,
        REG_LEFT_COLOR         = 3'd3,
        REG_RIGHT_COLOR        = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [6:0]  blend_percent;
        logic        use_drawing_colors;
        logic        clear_background;
        logic [23:0] left_color;
        logic [23:0] right_color;
    } cfg_t;

    // Pixel class, settled in the first stage
    typedef enum logic [2:0] {
        CLS_SKIP,
        CLS_BACK,
        CLS_DECAL,
        CLS_PCT_BLEND,
        CLS_SHADOW,
        CLS_MIX
    } cls_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } stage_ctl_t;

    localparam logic [6:0]  PCT_FULL      = 7'd100;
    localparam logic [7:0]  IDX_CLEAR     = 8'd255;
    localparam logic [7:0]  GREEN_CLEAR   = 8'd255;
    localparam logic [7:0]  GRAY_MID      = 8'd128;
    localparam logic [7:0]  AMOUNT_SCALE  = 8'd200;
    localparam logic [17:0] RECIP_100     = 18'd167773; // ceil(2^24 / 100)
    localparam logic [16:0] RECIP_255     = 17'd65794;  // ceil(2^24 / 255)

    // Exact floor(x / 100) for x below 102400
    function automatic logic [9:0] div100(input logic [16:0] x);
        logic [34:0] p;
        p = 35'(x) * 35'(RECIP_100);
        return p[33:24];
    endfunction

    // Exact floor(x / 255) for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [32:0] p;
        p = 33'(x) * 33'(RECIP_255);
        return p[31:24];
    endfunction

    function automatic logic [7:0] sat8(input logic [9:0] v);
        return (v > 10'd255) ? 8'd255 : v[7:0];
    endfunction

endpackage

FILE: hdl/dpb_datapath.sv
// ----------------------------------------------------------------------------
// dpb_datapath
// Five payload stages: classify and scale, first divide, mix divide,
// background blend, final divide and output register.
// ----------------------------------------------------------------------------
module dpb_datapath (
    input  logic                aclk,
    input  dpb_pkg::cfg_t       cfg,
    input  dpb_pkg::stage_ctl_t ctl,
    input  dpb_pkg::in_t        s_data,
    output dpb_pkg::out_t       m_data
);

    // ---------------- stage 1 ----------------
    dpb_pkg::cls_t cls1_reg, cls1_next;
    logic [7:0]    bk1_reg [3];
    logic [7:0]    dec1_reg [3];
    logic [14:0]   sum1_reg [3];
    logic [14:0]   sum1_next [3];
    logic [7:0]    la1_reg, ra1_reg;
    logic [6:0]    g1_reg;
    logic          neg1_reg;

    logic [6:0]    pct;
    logic [7:0]    dec [3];
    logic [7:0]    bk [3];
    logic          is_gray;
    logic [7:0]    shd_mag;
    logic          shd_neg;

    always_comb begin
        pct = (cfg.blend_percent > dpb_pkg::PCT_FULL) ? dpb_pkg::PCT_FULL
                                                      : cfg.blend_percent;
        dec[0] = s_data.decal_red;
        dec[1] = s_data.decal_green;
        dec[2] = s_data.decal_blue;
        bk[0]  = s_data.background_present ? s_data.back_red   : dpb_pkg::GRAY_MID;
        bk[1]  = s_data.background_present ? s_data.back_green : dpb_pkg::GRAY_MID;
        bk[2]  = s_data.background_present ? s_data.back_blue  : dpb_pkg::GRAY_MID;
        is_gray = (dec[0] == dec[1]) && (dec[0] == dec[2]);
        shd_neg = dec[0] < dpb_pkg::GRAY_MID;
        shd_mag = shd_neg ? (dpb_pkg::GRAY_MID - dec[0]) : (dec[0] - dpb_pkg::GRAY_MID);

        if (cfg.use_drawing_colors) begin
            if (is_gray) begin
                cls1_next = (dec[0] == dpb_pkg::GRAY_MID) ? dpb_pkg::CLS_SKIP
                                                          : dpb_pkg::CLS_SHADOW;
            end else if (dec[1] == dpb_pkg::GREEN_CLEAR) begin
                cls1_next = cfg.clear_background ? dpb_pkg::CLS_BACK : dpb_pkg::CLS_SKIP;
            end else begin
                cls1_next = dpb_pkg::CLS_MIX;
            end
        end else if (s_data.decal_index != dpb_pkg::IDX_CLEAR) begin
            cls1_next = (pct == dpb_pkg::PCT_FULL) ? dpb_pkg::CLS_DECAL
                                                   : dpb_pkg::CLS_PCT_BLEND;
        end else begin
            cls1_next = cfg.clear_background ? dpb_pkg::CLS_BACK : dpb_pkg::CLS_SKIP;
        end

        for (int k = 0; k < 3; k++) begin
            if (cfg.use_drawing_colors) begin
                // shadow offset magnitude: |t| * 2 * percent
                sum1_next[k] = 15'({shd_mag, 1'b0} * pct);
            end else begin
                sum1_next[k] = 15'(bk[k] * (dpb_pkg::PCT_FULL - pct)) + 15'(dec[k] * pct);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            cls1_reg <= cls1_next;
            for (int k = 0; k < 3; k++) begin
                bk1_reg[k]  <= bk[k];
                dec1_reg[k] <= dec[k];
                sum1_reg[k] <= sum1_next[k];
            end
            la1_reg  <= dpb_pkg::div255(16'(dec[0] * dpb_pkg::AMOUNT_SCALE));
            ra1_reg  <= dpb_pkg::div255(16'(dec[2] * dpb_pkg::AMOUNT_SCALE));
            g1_reg   <= 7'(dpb_pkg::div255(16'(dec[1] * dpb_pkg::PCT_FULL)));
            neg1_reg <= shd_neg;
        end
    end

    // ---------------- stage 2 ----------------
    dpb_pkg::cls_t cls2_reg;
    logic [7:0]    bk2_reg [3];
    logic [6:0]    g2_reg;
    logic [7:0]    res2_reg [3];
    logic [7:0]    res2_next [3];
    logic [16:0]   mix2_reg [3];
    logic [16:0]   mix2_next [3];

    logic [8:0]    shd_off;
    logic signed [10:0] shd_val [3];
    logic [7:0]    lc, rc;

    always_comb begin
        shd_off = 9'(dpb_pkg::div100(17'(sum1_reg[0])));
        for (int k = 0; k < 3; k++) begin
            shd_val[k] = neg1_reg ? (11'(bk1_reg[k]) - 11'(shd_off))
                                  : (11'(bk1_reg[k]) + 11'(shd_off));
        end
        for (int k = 0; k < 3; k++) begin
            case (cls1_reg)
                dpb_pkg::CLS_DECAL:     res2_next[k] = dec1_reg[k];
                dpb_pkg::CLS_BACK:      res2_next[k] = bk1_reg[k];
                dpb_pkg::CLS_PCT_BLEND: res2_next[k] = 8'(dpb_pkg::div100(17'(sum1_reg[k])));
                dpb_pkg::CLS_SHADOW: begin
                    if (shd_val[k] < 0)
                        res2_next[k] = 8'd0;
                    else
                        res2_next[k] = dpb_pkg::sat8(shd_val[k][9:0]);
                end
                default:                res2_next[k] = 8'd0;
            endcase
        end
        for (int k = 0; k < 3; k++) begin
            lc = (la1_reg != 8'd0) ? cfg.left_color[8*k +: 8]  : 8'd0;
            rc = (ra1_reg != 8'd0) ? cfg.right_color[8*k +: 8] : 8'd0;
            mix2_next[k] = 17'(lc * la1_reg) + 17'(rc * ra1_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[1]) begin
            cls2_reg <= cls1_reg;
            g2_reg   <= g1_reg;
            for (int k = 0; k < 3; k++) begin
                bk2_reg[k]  <= bk1_reg[k];
                res2_reg[k] <= res2_next[k];
                mix2_reg[k] <= mix2_next[k];
            end
        end
    end

    // ---------------- stage 3 ----------------
    dpb_pkg::cls_t cls3_reg;
    logic [7:0]    bk3_reg [3];
    logic [6:0]    g3_reg;
    logic [7:0]    res3_reg [3];
    logic [9:0]    mix3_reg [3];

    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            cls3_reg <= cls2_reg;
            g3_reg   <= g2_reg;
            for (int k = 0; k < 3; k++) begin
                bk3_reg[k]  <= bk2_reg[k];
                res3_reg[k] <= res2_reg[k];
                mix3_reg[k] <= dpb_pkg::div100(mix2_reg[k]);
            end
        end
    end

    // ---------------- stage 4 ----------------
    dpb_pkg::cls_t cls4_reg;
    logic [7:0]    res4_reg [3];
    logic [16:0]   blend4_reg [3];

    always_ff @(posedge aclk) begin
        if (ctl.load[3]) begin
            cls4_reg <= cls3_reg;
            for (int k = 0; k < 3; k++) begin
                res4_reg[k]   <= res3_reg[k];
                blend4_reg[k] <= 17'(mix3_reg[k] * (dpb_pkg::PCT_FULL - g3_reg))
                               + 17'(bk3_reg[k] * g3_reg);
            end
        end
    end

    // ---------------- stage 5: output register ----------------
    logic [7:0]    fin [3];
    dpb_pkg::out_t out_reg, out_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            fin[k] = (cls4_reg == dpb_pkg::CLS_MIX) ? dpb_pkg::sat8(dpb_pkg::div100(blend4_reg[k]))
                                                     : res4_reg[k];
        end
        out_next.write_pixel = (cls4_reg != dpb_pkg::CLS_SKIP);
        out_next.out_red     = fin[0];
        out_next.out_green   = fin[1];
        out_next.out_blue    = fin[2];
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[4]) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

FILE: hdl/decal_pixel_blend_unit.sv
// ----------------------------------------------------------------------------
// decal_pixel_blend_unit
// Blends a decal pixel over a background pixel, standard or drawing-color mode.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid, s_ready, s_data (dpb_pkg::in_t)  | in
//  result  | m_valid, m_ready, m_data (dpb_pkg::out_t) | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// Five register stages; one request per clock unless every stage is full and m_ready is low.
// Depth is set by the reciprocal multiplies for the divides by 255 and 100.
// Each stage takes new data when it is empty or its successor moves, so
// bubbles close up and the input keeps flowing while a result waits.
// Synchronous active-low reset clears stage valids and sets the config registers to defaults.
// ----------------------------------------------------------------------------
module decal_pixel_blend_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  dpb_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output dpb_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [23:0]   cfg_data
);

    localparam int N = dpb_pkg::NUM_STAGES;

    // ---------------- configuration registers ----------------
    dpb_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blend_percent      <= dpb_pkg::PCT_FULL;
            cfg_reg.use_drawing_colors <= 1'b0;
            cfg_reg.clear_background   <= 1'b0;
            cfg_reg.left_color         <= '0;
            cfg_reg.right_color        <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                dpb_pkg::REG_BLEND_PERCENT:      cfg_reg.blend_percent      <= cfg_data[6:0];
                dpb_pkg::REG_USE_DRAWING_COLORS: cfg_reg.use_drawing_colors <= cfg_data[0];
                dpb_pkg::REG_CLEAR_BACKGROUND:   cfg_reg.clear_background   <= cfg_data[0];
                dpb_pkg::REG_LEFT_COLOR:         cfg_reg.left_color         <= cfg_data;
                dpb_pkg::REG_RIGHT_COLOR:        cfg_reg.right_color        <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage valids and flow control ----------------
    logic [N-1:0] valid_reg, valid_next;
    logic [N-1:0] stage_rdy;
    logic [N-1:0] upstream_v;
    dpb_pkg::stage_ctl_t ctl;

    always_comb begin
        stage_rdy[N-1] = !valid_reg[N-1] || m_ready;
        for (int i = N - 2; i >= 0; i--) begin
            stage_rdy[i] = !valid_reg[i] || stage_rdy[i+1];
        end
        upstream_v = {valid_reg[N-2:0], s_valid};
        for (int i = 0; i < N; i++) begin
            valid_next[i]   = stage_rdy[i] ? upstream_v[i] : valid_reg[i];
            ctl.load[i]     = stage_rdy[i] && upstream_v[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_rdy[0];
    assign m_valid = valid_reg[N-1];

    dpb_datapath u_datapath (
        .aclk   (aclk),
        .cfg    (cfg_reg),
        .ctl    (ctl),
        .s_data (s_data),
        .m_data (m_data)
    );

    // ---------------- assertions ----------------
    a_skip_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.write_pixel) |->
            (m_data.out_red == 8'd0 && m_data.out_green == 8'd0 && m_data.out_blue == 8'd0))
        else $error("skipped pixel carries nonzero color");

    a_backpressure_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&valid_reg && !m_ready))
        else $error("input stalled while the pipeline has room");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && valid_reg == '0))
        else $error("stage valid set right after reset");

endmodule

FILE: sim/tb_decal_pixel_blend_unit.sv
// ----------------------------------------------------------------------------
// tb_decal_pixel_blend_unit
// Self-checking bench for the decal pixel blend unit. A behavioral blend model
// predicts every pixel as its request is accepted. Results are checked in
// order as they leave. Directed pixels cover both modes, then random
// traffic runs under many register settings with bursty input and an uneven
// result sink.
// ----------------------------------------------------------------------------
module tb_decal_pixel_blend_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum {RX_STEADY, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

    localparam int IN_W = $bits(dpb_pkg::in_t);

    logic          aclk;
    logic          aresetn   = 1'b0;
    logic          s_valid   = 1'b0;
    logic          s_ready;
    dpb_pkg::in_t  s_data    = '0;
    logic          m_valid;
    logic          m_ready   = 1'b0;
    dpb_pkg::out_t m_data;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [2:0]    cfg_index = '0;
    logic [23:0]   cfg_data  = '0;

    // local copy of the register file
    logic [6:0]  cfg_pct   = dpb_pkg::PCT_FULL;
    logic        cfg_draw  = 1'b0;
    logic        cfg_clear = 1'b0;
    logic [23:0] cfg_left  = '0;
    logic [23:0] cfg_right = '0;

    dpb_pkg::out_t expected_pixels[$];
    int unsigned mismatch_count = 0;
    int unsigned burst_left     = 0;

    // result sink
    int unsigned rx_hold_req  = 0;
    int unsigned rx_hold_left = 0;
    int unsigned rx_mode_left = 0;
    int unsigned rx_phase     = 0;
    rx_mode_t    rx_mode      = RX_STEADY;

    decal_pixel_blend_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int clamp_byte(input int v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return v;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // Expected result of one pixel under the current register settings
    function automatic dpb_pkg::out_t blend_pixel(input dpb_pkg::in_t px);
        int   pct, t, la, ra, g, lc, rc, mix;
        int   dec[3], bk[3], res[3];
        logic wr;
        dpb_pkg::out_t o;
        pct = (cfg_pct > dpb_pkg::PCT_FULL) ? 100 : int'(cfg_pct);
        dec[0] = px.decal_red;
        dec[1] = px.decal_green;
        dec[2] = px.decal_blue;
        bk[0]  = px.background_present ? int'(px.back_red)   : 128;
        bk[1]  = px.background_present ? int'(px.back_green) : 128;
        bk[2]  = px.background_present ? int'(px.back_blue)  : 128;
        res    = '{0, 0, 0};
        wr     = 1'b1;
        if (cfg_draw) begin
            if (dec[0] == dec[1] && dec[0] == dec[2]) begin
                t = dec[0] - 128;
                if (t == 0) begin
                    wr = 1'b0;
                end else begin
                    t = (t * 2 * pct) / 100;   // signed divide truncates toward zero
                    for (int k = 0; k < 3; k++) res[k] = clamp_byte(bk[k] + t);
                end
            end else if (dec[1] == 255) begin
                if (cfg_clear) res = bk;
                else wr = 1'b0;
            end else begin
                la = dec[0] * 200 / 255;
                ra = dec[2] * 200 / 255;
                g  = dec[1] * 100 / 255;
                for (int k = 0; k < 3; k++) begin
                    lc     = (la > 0) ? int'(cfg_left[8*k +: 8]) : 0;
                    rc     = (ra > 0) ? int'(cfg_right[8*k +: 8]) : 0;
                    mix    = (lc * la + rc * ra) / 100;
                    res[k] = clamp_byte((mix * (100 - g) + bk[k] * g) / 100);
                end
            end
        end else begin
            if (px.decal_index != dpb_pkg::IDX_CLEAR) begin
                for (int k = 0; k < 3; k++)
                    res[k] = (pct == 100) ? dec[k]
                           : clamp_byte((bk[k] * (100 - pct) + dec[k] * pct) / 100);
            end else if (cfg_clear) begin
                res = bk;
            end else begin
                wr = 1'b0;
            end
        end
        o.write_pixel = wr;
        o.out_red     = wr ? 8'(res[0]) : 8'd0;
        o.out_green   = wr ? 8'(res[1]) : 8'd0;
        o.out_blue    = wr ? 8'(res[2]) : 8'd0;
        return o;
    endfunction

    // Leaves valid high; the caller lowers it when the burst ends
    task automatic send_pixel(input dpb_pkg::in_t px);
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        expected_pixels.push_back(blend_pixel(px));
    endtask

    task automatic send_paced(input dpb_pkg::in_t px);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                s_data  <= dpb_pkg::in_t'(IN_W'({$urandom, $urandom}));
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
        burst_left--;
        send_pixel(px);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_pixels.size() != 0) @(posedge aclk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            dpb_pkg::REG_BLEND_PERCENT:      cfg_pct   = val[6:0];
            dpb_pkg::REG_USE_DRAWING_COLORS: cfg_draw  = val[0];
            dpb_pkg::REG_CLEAR_BACKGROUND:   cfg_clear = val[0];
            dpb_pkg::REG_LEFT_COLOR:         cfg_left  = val;
            dpb_pkg::REG_RIGHT_COLOR:        cfg_right = val;
            default: ;
        endcase
    endtask

    // Unused upper data bits carry noise; the block must mask them
    task automatic set_config(input logic [6:0] pct, input logic draw, input logic clr,
                              input logic [23:0] lc, input logic [23:0] rc);
        wait_for_results();
        write_reg(dpb_pkg::REG_BLEND_PERCENT,      {17'($urandom), pct});
        write_reg(dpb_pkg::REG_USE_DRAWING_COLORS, {23'($urandom), draw});
        write_reg(dpb_pkg::REG_CLEAR_BACKGROUND,   {23'($urandom), clr});
        write_reg(dpb_pkg::REG_LEFT_COLOR,         lc);
        write_reg(dpb_pkg::REG_RIGHT_COLOR,        rc);
        cfg_valid <= 1'b0;
    endtask

    function automatic dpb_pkg::in_t random_pixel();
        dpb_pkg::in_t px;
        px.decal_red          = rand_byte();
        px.decal_green        = rand_byte();
        px.decal_blue         = rand_byte();
        px.decal_index        = ($urandom_range(0, 5) == 0) ? dpb_pkg::IDX_CLEAR : rand_byte();
        px.background_present = ($urandom_range(0, 3) != 0);
        px.back_red           = rand_byte();
        px.back_green         = rand_byte();
        px.back_blue          = rand_byte();
        if (cfg_draw) begin
            case ($urandom_range(0, 5))
                0: begin
                    px.decal_green = px.decal_red;
                    px.decal_blue  = px.decal_red;
                end
                1: begin
                    px.decal_red   = dpb_pkg::GRAY_MID;
                    px.decal_green = dpb_pkg::GRAY_MID;
                    px.decal_blue  = dpb_pkg::GRAY_MID;
                end
                2: px.decal_green = dpb_pkg::GREEN_CLEAR;
                default: ;
            endcase
        end
        return px;
    endfunction

    task automatic test_reset_defaults();
        send_paced(dpb_pkg::in_t'{8'd12, 8'd34, 8'd56, 8'd0, 1'b1, 8'd200, 8'd100, 8'd50});
        send_paced(dpb_pkg::in_t'{8'd90, 8'd80, 8'd70, dpb_pkg::IDX_CLEAR, 1'b1,
                                  8'd1, 8'd2, 8'd3});
        send_paced(dpb_pkg::in_t'{8'd255, 8'd0, 8'd255, 8'd254, 1'b0, 8'd9, 8'd9, 8'd9});
    endtask

    task automatic test_standard_blend();
        set_config(7'd50, 1'b0, 1'b0, 24'h000000, 24'h000000);
        send_paced(dpb_pkg::in_t'{8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd255, 8'd255, 8'd255});
        send_paced(dpb_pkg::in_t'{8'd255, 8'd255, 8'd255, 8'd254, 1'b0, 8'd0, 8'd0, 8'd0});
        send_paced(dpb_pkg::in_t'{8'd40, 8'd50, 8'd60, dpb_pkg::IDX_CLEAR, 1'b1,
                                  8'd7, 8'd8, 8'd9});
        // percent above 100 saturates, so the decal color passes
        set_config(7'd120, 1'b0, 1'b1, 24'hFFFFFF, 24'hFFFFFF);
        send_paced(dpb_pkg::in_t'{8'd40, 8'd50, 8'd60, dpb_pkg::IDX_CLEAR, 1'b1,
                                  8'd7, 8'd8, 8'd9});
        send_paced(dpb_pkg::in_t'{8'd40, 8'd50, 8'd60, dpb_pkg::IDX_CLEAR, 1'b0,
                                  8'd7, 8'd8, 8'd9});
        send_paced(dpb_pkg::in_t'{rand_byte(), rand_byte(), rand_byte(), 8'd17, 1'b1,
                                  rand_byte(), rand_byte(), rand_byte()});
        set_config(7'd0, 1'b0, 1'b0, 24'h000000, 24'h000000);
        send_paced(dpb_pkg::in_t'{8'd255, 8'd0, 8'd128, 8'd3, 1'b1, 8'd11, 8'd222, 8'd133});
    endtask

    task automatic test_drawing_colors();
        set_config(dpb_pkg::PCT_FULL, 1'b1, 1'b0, 24'h4080FF, 24'hFF2010);
        send_paced(dpb_pkg::in_t'{8'd0, 8'd0, 8'd0, 8'd5, 1'b1, 8'd10, 8'd200, 8'd255});
        send_paced(dpb_pkg::in_t'{8'd255, 8'd255, 8'd255, 8'd5, 1'b0, 8'd0, 8'd0, 8'd0});
        send_paced(dpb_pkg::in_t'{dpb_pkg::GRAY_MID, dpb_pkg::GRAY_MID, dpb_pkg::GRAY_MID,
                                  8'd5, 1'b1, 8'd1, 8'd2, 8'd3});
        send_paced(dpb_pkg::in_t'{8'd3, dpb_pkg::GREEN_CLEAR, 8'd9, 8'd5, 1'b1,
                                  8'd1, 8'd2, 8'd3});
        send_paced(dpb_pkg::in_t'{8'd255, 8'd0, 8'd255, 8'd5, 1'b1, 8'd20, 8'd40, 8'd60});
        // both amounts round down to zero: no drawing color contributes
        send_paced(dpb_pkg::in_t'{8'd0, 8'd254, 8'd1, 8'd5, 1'b0, 8'd20, 8'd40, 8'd60});
        set_config(7'd37, 1'b1, 1'b1, 24'($urandom), 24'($urandom));
        // small negative offsets must truncate toward zero
        send_paced(dpb_pkg::in_t'{8'd127, 8'd127, 8'd127, 8'd5, 1'b1,
                                  8'd100, 8'd100, 8'd100});
        send_paced(dpb_pkg::in_t'{8'd120, 8'd120, 8'd120, 8'd5, 1'b1, 8'd100, 8'd0, 8'd255});
        send_paced(dpb_pkg::in_t'{8'd0, dpb_pkg::GREEN_CLEAR, 8'd255, 8'd5, 1'b0,
                                  8'd1, 8'd2, 8'd3});
        send_paced(dpb_pkg::in_t'{8'd77, dpb_pkg::GREEN_CLEAR, 8'd0, 8'd5, 1'b1,
                                  8'd1, 8'd2, 8'd3});
        // white is gray first, not transparent
        send_paced(dpb_pkg::in_t'{8'd255, 8'd255, 8'd255, 8'd5, 1'b1, 8'd250, 8'd5, 8'd128});
    endtask

    task automatic test_unused_index();
        wait_for_results();
        write_reg(3'(dpb_pkg::REG_RIGHT_COLOR) + 3'($urandom_range(1, 3)), 24'($urandom));
        cfg_valid <= 1'b0;
        send_paced(random_pixel());
        send_paced(random_pixel());
    endtask

    // Sink holds off while requests keep coming, so the pipe fills and stalls
    task automatic test_backpressure();
        rx_hold_req = 300;
        for (int n = 0; n < 40; n++) send_pixel(random_pixel());
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        logic [6:0]  pct;
        logic        clr;
        logic [23:0] lc, rc;
        for (int phase = 0; phase < 12; phase++) begin
            case ($urandom_range(0, 4))
                0: pct = 7'd0;
                1: pct = dpb_pkg::PCT_FULL;
                2: pct = 7'd127;
                3: pct = dpb_pkg::PCT_FULL + 7'd1;
                default: pct = 7'($urandom_range(0, 127));
            endcase
            lc  = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : 24'($urandom);
            rc  = ($urandom_range(0, 3) == 0) ? 24'h000000 : 24'($urandom);
            clr = 1'($urandom);
            if (phase == 0) begin
                pct = 7'd127; clr = 1'b1; lc = 24'hFFFFFF; rc = 24'hFFFFFF;
            end else if (phase == 1) begin
                pct = 7'd0; clr = 1'b0; lc = 24'h000000; rc = 24'h000000;
            end
            set_config(pct, 1'(phase % 2), clr, lc, rc);
            for (int n = 0; n < 85; n++) send_paced(random_pixel());
        end
    endtask

    always @(posedge aclk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 200);
            end
            rx_mode_left--;
            rx_phase++;
            case (rx_mode)
                RX_STEADY: m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom);
                RX_MOSTLY: m_ready <= ($urandom_range(0, 9) != 0);
                default:   m_ready <= ((rx_phase % 7) < 3);
            endcase
        end
    end

    always @(posedge aclk) begin : check_results
        dpb_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: result with no request pending: w=%0b rgb=%h/%h/%h",
                             m_data.write_pixel, m_data.out_red, m_data.out_green,
                             m_data.out_blue);
            end else begin
                want = expected_pixels.pop_front();
                if (m_data.write_pixel !== want.write_pixel ||
                    m_data.out_red     !== want.out_red ||
                    m_data.out_green   !== want.out_green ||
                    m_data.out_blue    !== want.out_blue) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("ERROR: pixel mismatch at %0t", $realtime);
                        $display("  expected w=%0b rgb=%h/%h/%h, got w=%0b rgb=%h/%h/%h",
                                 want.write_pixel, want.out_red, want.out_green,
                                 want.out_blue, m_data.write_pixel, m_data.out_red,
                                 m_data.out_green, m_data.out_blue);
                    end
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_standard_blend();
        test_drawing_colors();
        test_unused_index();
        test_backpressure();
        test_random_traffic();
        wait_for_results();
        repeat (4 * dpb_pkg::NUM_STAGES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/dpb_pkg.sv
hdl/dpb_datapath.sv
hdl/decal_pixel_blend_unit.sv
sim/tb_decal_pixel_blend_unit.sv
